// ===== src/myers_shortest_edit_script_assert.svh =====
// Assertion macros shared by the edit script block.
// Uses the clk and rst_n names of the module that includes it.
`ifndef MYERS_SHORTEST_EDIT_SCRIPT_ASSERT_SVH
`define MYERS_SHORTEST_EDIT_SCRIPT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MSES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MSES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSES_ASSERT_IMP(lbl, ante, cons, msg)
`define MSES_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/mses_pkg.sv =====
// Shared types and codes of the edit script block.
// No dependencies.
package mses_pkg;
  localparam int DEF_MAX_LEN = 32;

  localparam logic [1:0] MODE_SRC = 2'd0;
  localparam logic [1:0] MODE_TGT = 2'd1;
  localparam logic [1:0] MODE_RUN = 2'd2;

  typedef enum logic [1:0] {
    OP_KEEP   = 2'd0,
    OP_DELETE = 2'd1,
    OP_INSERT = 2'd2,
    OP_EMPTY  = 2'd3
  } op_t;

  // Request to the script emitter.
  typedef struct packed {
    logic go;
    logic empty;
  } emit_req_t;
endpackage

// ===== src/mses_byte_mem.sv =====
// Byte string store: one write port, one registered read port.
// Depends on nothing.
module mses_byte_mem #(
  parameter int MAX_LEN = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] waddr,
  input  logic [7:0]                                   wdata,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] raddr,
  output logic [7:0]                                   rdata
);
  logic [7:0] mem [MAX_LEN];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/mses_hist_mem.sv =====
// Round history store: one frontier row per search round, indexed {round, diagonal/2}.
// Depends on nothing.
module mses_hist_mem #(
  parameter int MAX_LEN = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [2*$clog2(2*MAX_LEN+1)-1:0]       waddr,
  input  logic [$clog2(4*MAX_LEN+1)-1:0]         wdata,
  input  logic [2*$clog2(2*MAX_LEN+1)-1:0]       raddr,
  output logic [$clog2(4*MAX_LEN+1)-1:0]         rdata
);
  localparam int DW    = $clog2(2*MAX_LEN+1);
  localparam int VW    = $clog2(4*MAX_LEN+1);
  localparam int DEPTH = (2*MAX_LEN+1) << DW;

  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/mses_engine.sv =====
// Greedy forward search and traceback over the round history store.
// Depends on mses_pkg and the assertion header.
`include "myers_shortest_edit_script_assert.svh"
module mses_engine #(
  parameter int MAX_LEN = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [$clog2(MAX_LEN+1)-1:0]                 n,
  input  logic [$clog2(MAX_LEN+1)-1:0]                 m,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] src_raddr,
  input  logic [7:0]                                   src_rdata,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] tgt_raddr,
  input  logic [7:0]                                   tgt_rdata,
  output logic                                         hist_we,
  output logic [2*$clog2(2*MAX_LEN+1)-1:0]             hist_waddr,
  output logic [$clog2(4*MAX_LEN+1)-1:0]               hist_wdata,
  output logic [2*$clog2(2*MAX_LEN+1)-1:0]             hist_raddr,
  input  logic [$clog2(4*MAX_LEN+1)-1:0]               hist_rdata,
  output logic                                         script_we,
  output logic [$clog2(2*MAX_LEN)-1:0]                 script_waddr,
  output mses_pkg::op_t                                script_op,
  output logic                                         done,
  output logic [$clog2(2*MAX_LEN+1)-1:0]               cnt
);
  import mses_pkg::*;

  localparam int LW  = $clog2(MAX_LEN+1);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW  = $clog2(2*MAX_LEN+1);
  localparam int VW  = $clog2(4*MAX_LEN+1);
  localparam int SW  = VW + 2;
  localparam int HAW = 2*DW;
  localparam int CW  = $clog2(2*MAX_LEN+1);
  localparam int SAW = $clog2(2*MAX_LEN);
  localparam logic [DW-1:0] D_TOP = DW'(2*MAX_LEN);

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_PICK, S_SNK, S_CMP, S_WR,
    S_TBK, S_TBKEEP, S_TBTAIL, S_DONE
  } state_t;

  state_t               state_r;
  logic                 tb_r;
  logic [DW-1:0]        d_r;
  logic signed [SW-1:0] k_r, x_r, y_r, sx_r, sy_r;
  logic [LW-1:0]        n_r, m_r;
  logic [VW-1:0]        lo_r;
  logic                 ins_r;
  logic [CW-1:0]        cnt_r;

  logic signed [SW-1:0] n_s, m_s, d_s, ka, kb, fl, fh, xn, pk, ex, ey;
  logic                 ins;

  function automatic logic [HAW-1:0] haddr(input logic [DW-1:0] row,
                                           input logic signed [SW-1:0] kk);
    logic signed [SW-1:0] ofs;
    ofs = kk + $signed(SW'(2*MAX_LEN));
    return {row, ofs[DW:1]};
  endfunction

  assign n_s = $signed({{(SW-LW){1'b0}}, n_r});
  assign m_s = $signed({{(SW-LW){1'b0}}, m_r});
  assign d_s = $signed({{(SW-DW){1'b0}}, d_r});
  // On an edge diagonal both reads fetch the one neighbor that exists.
  assign ka  = (k_r == -d_s) ? k_r + 1 : k_r - 1;
  assign kb  = (k_r == d_s) ? k_r - 1 : k_r + 1;
  assign fl  = $signed({2'b00, lo_r});
  assign fh  = $signed({2'b00, hist_rdata});

  always_comb begin
    if (k_r == -d_s) begin
      xn = fh;
    end else if (k_r == d_s) begin
      xn = fl + 1;
    end else if (fl < fh) begin
      xn = fh;
    end else begin
      xn = fl + 1;
    end
    ins = (k_r == -d_s) || ((k_r != d_s) && (fl < fh));
    pk  = ins ? k_r + 1 : k_r - 1;
    ex  = ins ? fh : fl;
    ey  = ex - pk;
  end

  // Rows read in a round are written only in the round before, so no bypass.
  always_comb begin
    hist_raddr   = haddr(d_r, (state_r == S_RDB) ? kb : ka);
    hist_we      = (state_r == S_WR) && (d_r != D_TOP);
    hist_waddr   = haddr(DW'(d_r + 1'b1), k_r);
    hist_wdata   = x_r[VW-1:0];
    src_raddr    = x_r[AW-1:0];
    tgt_raddr    = y_r[AW-1:0];
    script_waddr = cnt_r[SAW-1:0];
    script_we    = 1'b0;
    script_op    = OP_KEEP;
    case (state_r)
      S_TBKEEP: begin
        script_we = 1'b1;
        if ((x_r > sx_r) && (y_r > sy_r)) begin
          script_op = OP_KEEP;
        end else begin
          script_op = ins_r ? OP_INSERT : OP_DELETE;
        end
      end
      S_TBTAIL: begin
        script_we = (x_r > 0) && (y_r > 0);
        script_op = OP_KEEP;
      end
      default: begin
        script_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tb_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            n_r     <= n;
            m_r     <= m;
            d_r     <= '0;
            k_r     <= '0;
            x_r     <= '0;
            y_r     <= '0;
            tb_r    <= 1'b0;
            cnt_r   <= '0;
            state_r <= S_SNK;
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          lo_r    <= hist_rdata;
          state_r <= S_PICK;
        end
        S_PICK: begin
          if (!tb_r) begin
            x_r     <= xn;
            y_r     <= xn - k_r;
            state_r <= S_SNK;
          end else begin
            ins_r   <= ins;
            sx_r    <= ins ? ex : ex + 1;
            sy_r    <= ins ? ey + 1 : ey;
            state_r <= S_TBKEEP;
          end
        end
        S_SNK: begin
          if ((x_r < n_s) && (y_r < m_s) && (y_r >= 0)) begin
            state_r <= S_CMP;
          end else begin
            state_r <= S_WR;
          end
        end
        S_CMP: begin
          if (src_rdata == tgt_rdata) begin
            x_r     <= x_r + 1;
            y_r     <= y_r + 1;
            state_r <= S_SNK;
          end else begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          if ((x_r >= n_s) && (y_r >= m_s)) begin
            tb_r    <= 1'b1;
            x_r     <= n_s;
            y_r     <= m_s;
            state_r <= (d_r == '0) ? S_TBTAIL : S_TBK;
          end else if (k_r == d_s) begin
            d_r     <= DW'(d_r + 1'b1);
            k_r     <= -(d_s + 1);
            state_r <= S_RDA;
          end else begin
            k_r     <= k_r + 2;
            state_r <= S_RDA;
          end
        end
        S_TBK: begin
          k_r     <= x_r - y_r;
          state_r <= S_RDA;
        end
        S_TBKEEP: begin
          cnt_r <= cnt_r + 1'b1;
          if ((x_r > sx_r) && (y_r > sy_r)) begin
            x_r <= x_r - 1;
            y_r <= y_r - 1;
          end else begin
            if (ins_r) begin
              y_r <= y_r - 1;
            end else begin
              x_r <= x_r - 1;
            end
            d_r     <= DW'(d_r - 1'b1);
            state_r <= (d_r == DW'(1)) ? S_TBTAIL : S_TBK;
          end
        end
        S_TBTAIL: begin
          if ((x_r > 0) && (y_r > 0)) begin
            cnt_r <= cnt_r + 1'b1;
            x_r   <= x_r - 1;
            y_r   <= y_r - 1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = (state_r == S_DONE);
  assign cnt  = cnt_r;

  `MSES_ASSERT_IMP(a_start_idle, start, state_r == S_IDLE, "engine started while busy")
  `MSES_ASSERT_IMP(a_cnt_bound, done, cnt_r <= (CW'(n_r) + CW'(m_r)), "script longer than n+m")
  `MSES_ASSERT_IMP(a_push_tb, script_we, tb_r, "script push outside traceback")
  `MSES_ASSERT_IMP(a_round_bound, (state_r == S_WR) && !tb_r, d_r <= (CW'(n_r) + CW'(m_r)), "search round past n+m")
endmodule

// ===== src/mses_script.sv =====
// Script buffer and result emitter: replays pushed operations in reverse order.
// Depends on mses_pkg and the assertion header.
`include "myers_shortest_edit_script_assert.svh"
module mses_script #(
  parameter int MAX_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mses_pkg::emit_req_t               req,
  input  logic [$clog2(2*MAX_LEN+1)-1:0]    cnt,
  input  logic                              ovf,
  input  logic                              we,
  input  logic [$clog2(2*MAX_LEN)-1:0]      waddr,
  input  mses_pkg::op_t                     wdata,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [1:0]                        out_edit_op,
  output logic                              out_last_op,
  output logic                              out_overflow,
  output logic                              done
);
  import mses_pkg::*;

  localparam int CW  = $clog2(2*MAX_LEN+1);
  localparam int SAW = $clog2(2*MAX_LEN);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_LOAD, S_WAIT} state_t;

  state_t        state_r;
  logic [1:0]    mem [2*MAX_LEN];
  logic [1:0]    rdata_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] idx_dec;
  logic          out_valid_r, out_last_r, ovf_r, done_r;
  op_t           out_op_r;

  assign idx_dec = idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[idx_dec[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.go) begin
            ovf_r <= ovf;
            if (req.empty) begin
              out_op_r    <= OP_EMPTY;
              out_last_r  <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_WAIT;
            end else begin
              idx_r   <= cnt;
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_LOAD;
        S_LOAD: begin
          out_op_r    <= op_t'(rdata_r);
          out_last_r  <= (idx_r == CW'(1));
          out_valid_r <= 1'b1;
          idx_r       <= idx_dec;
          state_r     <= S_WAIT;
        end
        S_WAIT: begin
          // hold the beat until the receiver takes it
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_edit_op  = out_op_r;
  assign out_last_op  = out_last_r;
  assign out_overflow = ovf_r;
  assign done         = done_r;

  `MSES_ASSERT_IMP(a_valid_wait, out_valid_r, state_r == S_WAIT, "result shown outside wait")
  `MSES_ASSERT_NXT(a_last_drops, out_valid_r && out_ready && out_last_r, !out_valid_r, "valid after last beat")
  `MSES_ASSERT_IMP(a_req_idle, req.go, state_r == S_IDLE, "emit request while busy")
endmodule

// ===== src/myers_shortest_edit_script.sv =====
// Shortest edit script block, top level.
// Depends on mses_pkg, mses_byte_mem, mses_hist_mem, mses_engine, mses_script.
//
// Input channel (in_valid/in_ready): mode 0 appends in_byte_value to the
// source string, mode 1 to the target string, mode 2 runs the search; mode 3
// is ignored. Bytes past MAX_LEN are dropped and flag overflow on the next run.
// Load beats are accepted back to back.
// A run holds in_ready low until its whole script has been delivered. The
// search visits each diagonal of each round in turn and follows the
// matching bytes along it; the traceback walks back round by round and
// pushes one operation per step. Both read through the single read port
// of the round history RAM. Each result beat is fetched only after the
// one before it has been taken; a stalled beat holds its value until taken.
// Results (out_valid/out_ready): keep, delete, insert in forward order with
// out_last_op on the final beat; two empty strings give one empty marker.
// Reset (rst_n low, synchronous) empties both strings and clears the flag;
// no memory clearing is needed.
module myers_shortest_edit_script #(
  parameter int MAX_LEN = mses_pkg::DEF_MAX_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_edit_op,
  output logic       out_last_op,
  output logic       out_overflow
);
  import mses_pkg::*;

  localparam int LW  = $clog2(MAX_LEN+1);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW  = $clog2(2*MAX_LEN+1);
  localparam int VW  = $clog2(4*MAX_LEN+1);
  localparam int CW  = $clog2(2*MAX_LEN+1);
  localparam int SAW = $clog2(2*MAX_LEN);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  logic          busy_r, drop_r, ovf_r;
  logic [LW-1:0] src_len_r, tgt_len_r;
  logic          acc, run_acc, both_empty;
  logic          src_we, tgt_we;

  logic [AW-1:0]     src_raddr, tgt_raddr;
  logic [7:0]        src_rdata, tgt_rdata;
  logic              hist_we;
  logic [2*DW-1:0]   hist_waddr, hist_raddr;
  logic [VW-1:0]     hist_wdata, hist_rdata;
  logic              scr_we, eng_done, emit_done;
  logic [SAW-1:0]    scr_waddr;
  op_t               scr_op;
  logic [CW-1:0]     eng_cnt;
  emit_req_t         emit_req;

  assign in_ready   = !busy_r;
  assign acc        = in_valid && in_ready;
  assign run_acc    = acc && (in_mode == MODE_RUN);
  assign both_empty = (src_len_r == '0) && (tgt_len_r == '0);
  assign src_we     = acc && (in_mode == MODE_SRC) && (src_len_r < LEN_MAX);
  assign tgt_we     = acc && (in_mode == MODE_TGT) && (tgt_len_r < LEN_MAX);

  assign emit_req.go    = (run_acc && both_empty) || eng_done;
  assign emit_req.empty = run_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      drop_r    <= 1'b0;
      ovf_r     <= 1'b0;
      src_len_r <= '0;
      tgt_len_r <= '0;
    end else begin
      if (src_we) begin
        src_len_r <= src_len_r + 1'b1;
      end
      if (tgt_we) begin
        tgt_len_r <= tgt_len_r + 1'b1;
      end
      if (acc && (((in_mode == MODE_SRC) && !src_we) ||
                  ((in_mode == MODE_TGT) && !tgt_we))) begin
        drop_r <= 1'b1;
      end
      // lengths and flag start over once a run is taken; loads wait for the script
      if (run_acc) begin
        busy_r    <= 1'b1;
        ovf_r     <= drop_r;
        drop_r    <= 1'b0;
        src_len_r <= '0;
        tgt_len_r <= '0;
      end
      if (emit_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  mses_byte_mem #(.MAX_LEN(MAX_LEN)) u_src (
    .clk(clk), .we(src_we), .waddr(src_len_r[AW-1:0]), .wdata(in_byte_value),
    .raddr(src_raddr), .rdata(src_rdata)
  );

  mses_byte_mem #(.MAX_LEN(MAX_LEN)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(tgt_len_r[AW-1:0]), .wdata(in_byte_value),
    .raddr(tgt_raddr), .rdata(tgt_rdata)
  );

  mses_hist_mem #(.MAX_LEN(MAX_LEN)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  mses_engine #(.MAX_LEN(MAX_LEN)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .start(run_acc && !both_empty), .n(src_len_r), .m(tgt_len_r),
    .src_raddr(src_raddr), .src_rdata(src_rdata),
    .tgt_raddr(tgt_raddr), .tgt_rdata(tgt_rdata),
    .hist_we(hist_we), .hist_waddr(hist_waddr), .hist_wdata(hist_wdata),
    .hist_raddr(hist_raddr), .hist_rdata(hist_rdata),
    .script_we(scr_we), .script_waddr(scr_waddr), .script_op(scr_op),
    .done(eng_done), .cnt(eng_cnt)
  );

  mses_script #(.MAX_LEN(MAX_LEN)) u_script (
    .clk(clk), .rst_n(rst_n), .req(emit_req), .cnt(eng_cnt),
    .ovf(run_acc ? drop_r : ovf_r),
    .we(scr_we), .waddr(scr_waddr), .wdata(scr_op),
    .out_ready(out_ready), .out_valid(out_valid), .out_edit_op(out_edit_op),
    .out_last_op(out_last_op), .out_overflow(out_overflow), .done(emit_done)
  );
endmodule
